// File: rtl/core/hrs_pkg.sv
package hrs_pkg;

  localparam int MAX_REQUEST_BYTES = 65536;
  localparam int MAX_HEADERS = 32;

  localparam int POS_W = $clog2(MAX_REQUEST_BYTES + 1);
  localparam int HDR_W = $clog2(MAX_HEADERS + 1);

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [HDR_W-1:0] hdr_cnt_t;
  typedef logic [16:0] seg_off_t;
  typedef logic [4:0] slot_t;
  typedef logic [2:0] kind_t;
  typedef logic [2:0] fault_t;

  localparam kind_t KIND_METHOD  = 3'd0;
  localparam kind_t KIND_TARGET  = 3'd1;
  localparam kind_t KIND_VERSION = 3'd2;
  localparam kind_t KIND_NAME    = 3'd3;
  localparam kind_t KIND_VALUE   = 3'd4;
  localparam kind_t KIND_BODY    = 3'd5;
  localparam kind_t KIND_ERROR   = 3'd6;

  localparam fault_t FAULT_NONE     = 3'd0;
  localparam fault_t FAULT_REQ_LINE = 3'd1;
  localparam fault_t FAULT_NO_COLON = 3'd2;
  localparam fault_t FAULT_TRUNC    = 3'd3;
  localparam fault_t FAULT_LIMIT    = 3'd4;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;

  localparam pos_t POS_LIMIT = pos_t'(MAX_REQUEST_BYTES);
  localparam hdr_cnt_t HDR_LIMIT = hdr_cnt_t'(MAX_HEADERS);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } req_item_t;

  typedef struct packed {
    kind_t    segment_kind;
    seg_off_t seg_start;
    seg_off_t seg_end;
    slot_t    header_slot;
    fault_t   fault_code;
  } seg_item_t;

  typedef struct packed {
    logic      valid;
    seg_item_t item;
  } seg_result_t;

  function automatic seg_off_t to_off(pos_t p);
    return seg_off_t'(p);
  endfunction

endpackage

// File: rtl/core/hrs_parser.sv
module hrs_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  hrs_pkg::req_item_t  req,
  output hrs_pkg::seg_result_t result
);

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_TARGET,
    PH_VERSION,
    PH_NAME,
    PH_SKIP,
    PH_VALUE,
    PH_BODY,
    PH_DRAIN
  } phase_t;

  phase_t            phase, phase_next;
  logic              saw_cr, saw_cr_next;
  hrs_pkg::pos_t     byte_pos, byte_pos_next;
  hrs_pkg::pos_t     seg_begin, seg_begin_next;
  hrs_pkg::pos_t     body_begin, body_begin_next;
  hrs_pkg::hdr_cnt_t headers_seen, headers_seen_next;
  hrs_pkg::fault_t   fault;
  logic              crlf;

  function automatic hrs_pkg::seg_result_t make_seg(hrs_pkg::kind_t kind, hrs_pkg::pos_t seg_lo,
                                                   hrs_pkg::pos_t seg_hi, hrs_pkg::slot_t slot,
                                                   hrs_pkg::fault_t code);
    hrs_pkg::seg_result_t r;
    r.valid             = 1'b1;
    r.item.segment_kind = kind;
    r.item.seg_start    = hrs_pkg::to_off(seg_lo);
    r.item.seg_end      = hrs_pkg::to_off(seg_hi);
    r.item.header_slot  = slot;
    r.item.fault_code   = code;
    return r;
  endfunction

  always_comb begin
    phase_next        = phase;
    saw_cr_next       = saw_cr;
    byte_pos_next     = byte_pos;
    seg_begin_next    = seg_begin;
    body_begin_next   = body_begin;
    headers_seen_next = headers_seen;
    result            = '0;
    fault             = hrs_pkg::FAULT_NONE;
    crlf              = saw_cr && (req.data_byte == hrs_pkg::CH_LF);

    if (phase != PH_DRAIN) begin
      if (byte_pos >= hrs_pkg::POS_LIMIT) begin
        fault = hrs_pkg::FAULT_LIMIT;
      end else begin
        case (phase)
          PH_METHOD, PH_TARGET: begin
            if (crlf) begin
              fault = hrs_pkg::FAULT_REQ_LINE;
            end else if (req.data_byte == hrs_pkg::CH_SP) begin
              result = make_seg((phase == PH_METHOD) ? hrs_pkg::KIND_METHOD
                                                     : hrs_pkg::KIND_TARGET,
                                seg_begin, byte_pos, '0, hrs_pkg::FAULT_NONE);
              seg_begin_next = byte_pos + 1'b1;
              phase_next = (phase == PH_METHOD) ? PH_TARGET : PH_VERSION;
            end
          end
          PH_VERSION: begin
            if (crlf) begin
              result = make_seg(hrs_pkg::KIND_VERSION, seg_begin, byte_pos - 1'b1, '0,
                                hrs_pkg::FAULT_NONE);
              seg_begin_next = byte_pos + 1'b1;
              phase_next = PH_NAME;
            end
          end
          PH_NAME: begin
            if (crlf) begin
              // empty line closes the header block
              if (seg_begin == byte_pos - 1'b1) begin
                body_begin_next = byte_pos + 1'b1;
                phase_next = PH_BODY;
              end else begin
                fault = hrs_pkg::FAULT_NO_COLON;
              end
            end else if (req.data_byte == hrs_pkg::CH_COLON) begin
              if (headers_seen >= hrs_pkg::HDR_LIMIT) begin
                fault = hrs_pkg::FAULT_LIMIT;
              end else begin
                result = make_seg(hrs_pkg::KIND_NAME, seg_begin, byte_pos,
                                  hrs_pkg::slot_t'(headers_seen), hrs_pkg::FAULT_NONE);
                phase_next = PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            if (req.data_byte != hrs_pkg::CH_SP && req.data_byte != hrs_pkg::CH_TAB) begin
              seg_begin_next = byte_pos;
              phase_next = PH_VALUE;
            end
          end
          PH_VALUE: begin
            if (crlf) begin
              result = make_seg(hrs_pkg::KIND_VALUE, seg_begin, byte_pos - 1'b1,
                                hrs_pkg::slot_t'(headers_seen), hrs_pkg::FAULT_NONE);
              headers_seen_next = headers_seen + 1'b1;
              seg_begin_next = byte_pos + 1'b1;
              phase_next = PH_NAME;
            end
          end
          default: begin
          end
        endcase
        saw_cr_next   = (req.data_byte == hrs_pkg::CH_CR);
        byte_pos_next = byte_pos + 1'b1;
      end

      if (fault != hrs_pkg::FAULT_NONE) begin
        result = make_seg(hrs_pkg::KIND_ERROR, byte_pos, byte_pos, '0, fault);
        phase_next = PH_DRAIN;
      end
    end

    if (req.final_byte) begin
      if (phase_next == PH_BODY) begin
        result = make_seg(hrs_pkg::KIND_BODY, body_begin_next, byte_pos + 1'b1, '0,
                          hrs_pkg::FAULT_NONE);
      end else if (phase_next != PH_DRAIN) begin
        // request ended before the blank line
        result = make_seg(hrs_pkg::KIND_ERROR, byte_pos, byte_pos, '0, hrs_pkg::FAULT_TRUNC);
      end
      phase_next        = PH_METHOD;
      saw_cr_next       = 1'b0;
      byte_pos_next     = '0;
      seg_begin_next    = '0;
      body_begin_next   = '0;
      headers_seen_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_METHOD;
      saw_cr       <= 1'b0;
      byte_pos     <= '0;
      seg_begin    <= '0;
      body_begin   <= '0;
      headers_seen <= '0;
    end else if (step) begin
      phase        <= phase_next;
      saw_cr       <= saw_cr_next;
      byte_pos     <= byte_pos_next;
      seg_begin    <= seg_begin_next;
      body_begin   <= body_begin_next;
      headers_seen <= headers_seen_next;
    end
  end

endmodule

// File: rtl/core/hrs_out_buf.sv
module hrs_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  hrs_pkg::seg_result_t push,
  output logic                 full,
  output logic                 valid,
  input  logic                 ready,
  output hrs_pkg::seg_item_t   item
);

  logic               main_valid;
  logic               skid_valid;
  hrs_pkg::seg_item_t main_item;
  hrs_pkg::seg_item_t skid_item;
  logic               pop;

  assign pop   = main_valid && ready;
  assign valid = main_valid;
  assign item  = main_item;
  assign full  = skid_valid;

  // a push never arrives while the skid entry is occupied
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push.valid;
      end
    end else if (push.valid) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      main_item <= skid_valid ? skid_item : push.item;
    end else if (push.valid && !main_valid) begin
      main_item <= push.item;
    end
    if (!pop && push.valid && main_valid) begin
      skid_item <= push.item;
    end
  end

endmodule

// File: rtl/core/http_request_segmenter.sv
// a segment is offered on seg after its closing byte passes the byte register, the parse
//   (combinational) and the result buffer; bytes that close no segment give nothing
// throughput: one request byte per cycle while the two-entry result buffer is not full
// reset: synchronous rst returns the parser to the method phase at offset zero and
//   empties the byte register and result buffer
module http_request_segmenter (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  hrs_pkg::req_item_t req,
  output logic               seg_valid,
  input  logic               seg_ready,
  output hrs_pkg::seg_item_t seg
);

  logic                 hold_valid;
  hrs_pkg::req_item_t   hold;
  logic                 step;
  logic                 buf_full;
  hrs_pkg::seg_result_t result;
  hrs_pkg::seg_result_t pushed;

  assign step      = hold_valid && !buf_full;
  assign req_ready = !hold_valid || !buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_ready) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      hold <= req;
    end
  end

  hrs_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .req    (hold),
    .result (result)
  );

  assign pushed.valid = result.valid && step;
  assign pushed.item  = result.item;

  hrs_out_buf u_out_buf (
    .clk   (clk),
    .rst   (rst),
    .push  (pushed),
    .full  (buf_full),
    .valid (seg_valid),
    .ready (seg_ready),
    .item  (seg)
  );

endmodule

// File: rtl/core/hrs_checker.sv
module hrs_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input hrs_pkg::req_item_t req,
  input logic               seg_valid,
  input logic               seg_ready,
  input hrs_pkg::seg_item_t seg
);

  // stalled segment must hold
  a_seg_hold: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_ready |=> seg_valid && $stable(seg))
    else $error("segment changed while stalled");

  // stalled request must hold
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !seg_valid)
    else $error("segment offered right after reset");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg.segment_kind == hrs_pkg::KIND_ERROR |->
      seg.seg_start == seg.seg_end && seg.fault_code != hrs_pkg::FAULT_NONE &&
      seg.header_slot == '0)
    else $error("malformed error segment");

  a_plain_shape: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg.segment_kind != hrs_pkg::KIND_ERROR |->
      seg.fault_code == hrs_pkg::FAULT_NONE &&
      (seg.segment_kind == hrs_pkg::KIND_METHOD || seg.segment_kind == hrs_pkg::KIND_TARGET ||
       seg.segment_kind == hrs_pkg::KIND_VERSION || seg.segment_kind == hrs_pkg::KIND_NAME ||
       seg.segment_kind == hrs_pkg::KIND_VALUE || seg.segment_kind == hrs_pkg::KIND_BODY))
    else $error("bad kind or fault on segment");

endmodule

bind http_request_segmenter hrs_checker u_hrs_checker (.*);
